@@ design/gpms_pkg.sv @@
package gpms_pkg;

  // Window length of the moving average
  localparam int SPAN = 8;

  localparam int EYE_W  = 16;
  localparam int COEF_W = 32;
  localparam int SCR_W  = 12;
  localparam int OUT_W  = 12;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 64;

  localparam int SUM_W  = VAL_W + $clog2(SPAN);
  localparam int CNT_W  = $clog2(SPAN + 1);
  localparam int SLOT_W = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int NUM_W  = SUM_W;
  localparam int DEN_W  = CNT_W + 4;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // Largest clamped value: 4095 pixels in Q12.4
  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(4095 * 16);

  localparam logic signed [COEF_W-1:0] RST_COEF_LIN = 32'sd65536;
  localparam logic [SCR_W-1:0]         RST_SCR_W    = 12'd1920;
  localparam logic [SCR_W-1:0]         RST_SCR_H    = 12'd1080;

  typedef enum logic [3:0] {
    REG_X_CONST = 4'd0,
    REG_X_LIN   = 4'd1,
    REG_X_SQ    = 4'd2,
    REG_Y_CONST = 4'd3,
    REG_Y_LIN   = 4'd4,
    REG_Y_SQ    = 4'd5,
    REG_SCR_W   = 4'd6,
    REG_SCR_H   = 4'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_FIN,
    ST_CLAMP,
    ST_HIST,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    acc_op_t                   acc_op;
    logic signed [COEF_W-1:0]  mul_a;
    logic signed [COEF_W-1:0]  mul_b;
  } mac_ctl_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ design/gpms_mac.sv @@
module gpms_mac (
  input  logic                                   clk,
  input  gpms_pkg::mac_ctl_t                     ctl,
  output logic signed [gpms_pkg::PROD_W-1:0]     prod,
  output logic signed [gpms_pkg::PROD_W-1:0]     acc
);

  logic signed [gpms_pkg::COEF_W-1:0] op_a;
  logic signed [gpms_pkg::COEF_W-1:0] op_b;
  logic signed [gpms_pkg::PROD_W-1:0] prod_r;
  logic signed [gpms_pkg::PROD_W-1:0] acc_r;

  assign op_a = $signed(ctl.mul_a);
  assign op_b = $signed(ctl.mul_b);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    unique case (ctl.acc_op)
      gpms_pkg::ACC_LOAD: acc_r <= prod_r;
      gpms_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      gpms_pkg::ACC_HOLD: acc_r <= acc_r;
      default:            acc_r <= acc_r;
    endcase
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

@@ design/gpms_div.sv @@
module gpms_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gpms_pkg::div_req_t req,
  output gpms_pkg::div_rsp_t rsp
);

  logic [gpms_pkg::NUM_W-1:0]  num_r;
  logic [gpms_pkg::DEN_W-1:0]  den_r;
  logic [gpms_pkg::DEN_W-1:0]  rem_r;
  logic [gpms_pkg::DEN_W-1:0]  rem_nxt;
  logic [gpms_pkg::DCNT_W-1:0] cnt_r;
  logic                        done_r;
  logic [gpms_pkg::DEN_W:0]    rem_sh;
  logic [gpms_pkg::DEN_W:0]    diff;
  logic                        ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, num_r[gpms_pkg::NUM_W-1]};
    diff    = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[gpms_pkg::DEN_W-1:0] : rem_sh[gpms_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= gpms_pkg::DCNT_W'(gpms_pkg::NUM_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == gpms_pkg::DCNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - gpms_pkg::DCNT_W'(1);
      end
    end
  end

  // Quotient bits shift into the numerator register from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[gpms_pkg::NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r[gpms_pkg::OUT_W-1:0];

endmodule

@@ design/gaze_polynomial_map_smooth_unit.sv @@
// Gaze mapper: one eye reference point per beat on the in_ channel, one
// smoothed screen point per beat on the out_ channel.
// Each axis runs a quadratic polynomial (coefficients written through the
// cfg_ channel, register index 0..7, cfg_ready high out of reset), is rounded
// to Q12.4, clamped to [0, screen size], and averaged over the last eight
// values. The output is that mean rounded to whole pixels.
// Sequencing: an accepted beat is carried through both axes before in_ready
// rises again, in the same cycle that out_valid goes high for its result, so the
// unit works on one item at a time. Per axis, four products go through one shared
// 32x32 multiplier, and the mean goes through a restoring divider (19-bit numerator).
// The output register holds a finished result while the next item is
// already accepted and computed; if out_ready is still low when the next
// result is ready, the sequencer waits and in_ready stays low.
// Reset (rst_n low, synchronous) restores the default coefficients and the
// 1920x1080 screen, empties the averaging window and drops any pending beat.
module gaze_polynomial_map_smooth_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [3:0]                         cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gpms_pkg::EYE_W-1:0]  in_eye_x,
  input  logic signed [gpms_pkg::EYE_W-1:0]  in_eye_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gpms_pkg::OUT_W-1:0]         out_screen_x,
  output logic [gpms_pkg::OUT_W-1:0]         out_screen_y
);

  gpms_pkg::state_t state_r, state_nxt;

  logic signed [gpms_pkg::COEF_W-1:0] cx0_r, cx1_r, cx2_r;
  logic signed [gpms_pkg::COEF_W-1:0] cy0_r, cy1_r, cy2_r;
  logic [gpms_pkg::SCR_W-1:0]         scr_w_r, scr_h_r;

  logic signed [gpms_pkg::EYE_W-1:0]  ex_r, ey_r;
  logic signed [gpms_pkg::COEF_W-1:0] esq_r, esq_nxt;
  logic                               ax_r, ax_nxt;
  logic [gpms_pkg::VAL_W-1:0]         vx_r, vx_nxt, vy_r, vy_nxt;
  logic [gpms_pkg::SUM_W-1:0]         sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [gpms_pkg::CNT_W-1:0]         fill_r, fill_nxt;
  logic [gpms_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic [gpms_pkg::OUT_W-1:0]         qx_r, qx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [gpms_pkg::OUT_W-1:0]         out_x_r, out_y_r;
  logic                               out_load;
  logic                               hist_we;

  logic [gpms_pkg::VAL_W-1:0] hist_x [gpms_pkg::SPAN];
  logic [gpms_pkg::VAL_W-1:0] hist_y [gpms_pkg::SPAN];
  logic [gpms_pkg::VAL_W-1:0] rd_x_r, rd_y_r;

  gpms_pkg::mac_ctl_t mac_ctl;
  gpms_pkg::div_req_t div_req;
  gpms_pkg::div_rsp_t div_rsp;
  logic signed [gpms_pkg::PROD_W-1:0] prod, acc;

  logic signed [gpms_pkg::EYE_W-1:0]  e_sel;
  logic signed [gpms_pkg::COEF_W-1:0] e_ext;
  logic signed [gpms_pkg::COEF_W-1:0] c0_sel, c1_sel, c2_sel;
  logic [gpms_pkg::SCR_W-1:0]         scr_sel;
  logic [gpms_pkg::PROD_W-1:0]        rnd;
  logic [gpms_pkg::PROD_W-21:0]       q_hi;
  logic [gpms_pkg::VAL_W-1:0]         top_v, clamp_v;
  logic                               full;

  gpms_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .prod (prod),
    .acc  (acc)
  );

  gpms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready = rst_n;

  // Axis operand selection
  always_comb begin
    e_sel   = ax_r ? ey_r : ex_r;
    e_ext   = 32'(e_sel);
    c0_sel  = ax_r ? cy0_r : cx0_r;
    c1_sel  = ax_r ? cy1_r : cx1_r;
    c2_sel  = ax_r ? cy2_r : cx2_r;
    scr_sel = ax_r ? scr_h_r : scr_w_r;
  end

  // Round the 2^-24 accumulator to Q12.4 and clamp to the screen
  always_comb begin
    rnd   = acc + 64'sd524288;
    q_hi  = rnd[gpms_pkg::PROD_W-1:20];
    top_v = {scr_sel, 4'b0000};
    if (acc <= 64'sd0) begin
      clamp_v = '0;
    end else if (q_hi > {28'd0, top_v}) begin
      clamp_v = top_v;
    end else begin
      clamp_v = q_hi[gpms_pkg::VAL_W-1:0];
    end
  end

  assign full = (fill_r == gpms_pkg::CNT_W'(gpms_pkg::SPAN));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpms_pkg::ST_IDLE:    if (in_valid) state_nxt = gpms_pkg::ST_SQ;
      gpms_pkg::ST_SQ:      state_nxt = gpms_pkg::ST_C0;
      gpms_pkg::ST_C0:      state_nxt = gpms_pkg::ST_C1;
      gpms_pkg::ST_C1:      state_nxt = gpms_pkg::ST_C2;
      gpms_pkg::ST_C2:      state_nxt = gpms_pkg::ST_FIN;
      gpms_pkg::ST_FIN:     state_nxt = gpms_pkg::ST_CLAMP;
      gpms_pkg::ST_CLAMP:   state_nxt = ax_r ? gpms_pkg::ST_HIST : gpms_pkg::ST_SQ;
      gpms_pkg::ST_HIST:    state_nxt = gpms_pkg::ST_DIV_GO;
      gpms_pkg::ST_DIV_GO:  state_nxt = gpms_pkg::ST_DIV_RUN;
      gpms_pkg::ST_DIV_RUN: begin
        if (div_rsp.done) begin
          state_nxt = ax_r ? gpms_pkg::ST_OUT : gpms_pkg::ST_DIV_GO;
        end
      end
      gpms_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = gpms_pkg::ST_IDLE;
      end
      default:              state_nxt = gpms_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready       = 1'b0;
    mac_ctl.acc_op = gpms_pkg::ACC_HOLD;
    mac_ctl.mul_a  = '0;
    mac_ctl.mul_b  = '0;
    div_req.start  = 1'b0;
    div_req.num    = (ax_r ? sum_y_r : sum_x_r) + gpms_pkg::SUM_W'({fill_r, 3'b000});
    div_req.den    = {fill_r, 4'b0000};
    ax_nxt         = ax_r;
    esq_nxt        = esq_r;
    vx_nxt         = vx_r;
    vy_nxt         = vy_r;
    sum_x_nxt      = sum_x_r;
    sum_y_nxt      = sum_y_r;
    fill_nxt       = fill_r;
    slot_nxt       = slot_r;
    qx_nxt         = qx_r;
    hist_we        = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      gpms_pkg::ST_IDLE: begin
        in_ready = rst_n;
        ax_nxt   = 1'b0;
      end
      gpms_pkg::ST_SQ: begin
        mac_ctl.mul_a = e_ext;
        mac_ctl.mul_b = e_ext;
      end
      gpms_pkg::ST_C0: begin
        esq_nxt       = prod[gpms_pkg::COEF_W-1:0];
        mac_ctl.mul_a = c0_sel;
        mac_ctl.mul_b = 32'sd256;
      end
      gpms_pkg::ST_C1: begin
        mac_ctl.acc_op = gpms_pkg::ACC_LOAD;
        mac_ctl.mul_a  = c1_sel;
        mac_ctl.mul_b  = e_ext <<< 4;
      end
      gpms_pkg::ST_C2: begin
        mac_ctl.acc_op = gpms_pkg::ACC_ADD;
        mac_ctl.mul_a  = c2_sel;
        mac_ctl.mul_b  = esq_r;
      end
      gpms_pkg::ST_FIN: begin
        mac_ctl.acc_op = gpms_pkg::ACC_ADD;
      end
      gpms_pkg::ST_CLAMP: begin
        if (ax_r) begin
          vy_nxt = clamp_v;
        end else begin
          vx_nxt = clamp_v;
        end
        ax_nxt = ~ax_r;
      end
      gpms_pkg::ST_HIST: begin
        // Drop the oldest entry once the window is full
        hist_we = 1'b1;
        if (full) begin
          sum_x_nxt = sum_x_r - gpms_pkg::SUM_W'(rd_x_r) + gpms_pkg::SUM_W'(vx_r);
          sum_y_nxt = sum_y_r - gpms_pkg::SUM_W'(rd_y_r) + gpms_pkg::SUM_W'(vy_r);
        end else begin
          sum_x_nxt = sum_x_r + gpms_pkg::SUM_W'(vx_r);
          sum_y_nxt = sum_y_r + gpms_pkg::SUM_W'(vy_r);
          fill_nxt  = fill_r + gpms_pkg::CNT_W'(1);
        end
        if (slot_r == gpms_pkg::SLOT_W'(gpms_pkg::SPAN - 1)) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + gpms_pkg::SLOT_W'(1);
        end
        ax_nxt = 1'b0;
      end
      gpms_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
      end
      gpms_pkg::ST_DIV_RUN: begin
        if (div_rsp.done && !ax_r) begin
          qx_nxt = div_rsp.quo;
          ax_nxt = 1'b1;
        end
      end
      gpms_pkg::ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpms_pkg::ST_IDLE;
      ax_r        <= 1'b0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      cx0_r       <= '0;
      cx1_r       <= gpms_pkg::RST_COEF_LIN;
      cx2_r       <= '0;
      cy0_r       <= '0;
      cy1_r       <= gpms_pkg::RST_COEF_LIN;
      cy2_r       <= '0;
      scr_w_r     <= gpms_pkg::RST_SCR_W;
      scr_h_r     <= gpms_pkg::RST_SCR_H;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          gpms_pkg::REG_X_CONST: cx0_r   <= $signed(cfg_data);
          gpms_pkg::REG_X_LIN:   cx1_r   <= $signed(cfg_data);
          gpms_pkg::REG_X_SQ:    cx2_r   <= $signed(cfg_data);
          gpms_pkg::REG_Y_CONST: cy0_r   <= $signed(cfg_data);
          gpms_pkg::REG_Y_LIN:   cy1_r   <= $signed(cfg_data);
          gpms_pkg::REG_Y_SQ:    cy2_r   <= $signed(cfg_data);
          gpms_pkg::REG_SCR_W:   scr_w_r <= cfg_data[gpms_pkg::SCR_W-1:0];
          gpms_pkg::REG_SCR_H:   scr_h_r <= cfg_data[gpms_pkg::SCR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ex_r <= in_eye_x;
      ey_r <= in_eye_y;
    end
    esq_r <= esq_nxt;
    vx_r  <= vx_nxt;
    vy_r  <= vy_nxt;
    qx_r  <= qx_nxt;
    if (out_load) begin
      out_x_r <= qx_r;
      out_y_r <= div_rsp.quo;
    end
  end

  // Averaging window, read at the slot about to be overwritten
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_x[slot_r] <= vx_r;
      hist_y[slot_r] <= vy_r;
    end
    rd_x_r <= hist_x[slot_r];
    rd_y_r <= hist_y[slot_r];
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = out_x_r;
  assign out_screen_y = out_y_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= gpms_pkg::CNT_W'(gpms_pkg::SPAN))
    else $error("window fill count beyond span");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_x_r <= gpms_pkg::SUM_W'(fill_r) * gpms_pkg::SUM_W'(gpms_pkg::VAL_MAX)) &&
    (sum_y_r <= gpms_pkg::SUM_W'(fill_r) * gpms_pkg::SUM_W'(gpms_pkg::VAL_MAX)))
    else $error("window sum exceeds its entries");

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (fill_r != '0))
    else $error("result issued from an empty window");

endmodule
